// ----- design/iwf_pkg.sv -----
// Package for the interior wall finder: sizes, register codes, the
// position record passed from the scan counters to the window logic.
// No dependencies; every other design file but iwf_ram imports it.
package iwf_pkg;

  // Largest map the line buffers hold.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Counter widths follow from the map limits.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CNT_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

  // Fixed field widths of the ports.
  localparam int CODE_W    = 8;
  localparam int OUT_W     = 10;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int EXT_W     = (CNT_W > DIM_W) ? CNT_W : DIM_W;

  // Character that marks a wall, and the reset map size.
  localparam logic [CODE_W-1:0] WALL_CODE = CODE_W'(35);
  localparam int                DIM_RESET = 64;
  localparam int                DIM_MIN   = 3;

  // Each line buffer entry holds the wall bits of the two rows above.
  localparam int LB_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position of the cell being processed, from the scan counters.
  typedef struct packed {
    logic             active;    // cell lies inside the current map
    logic             interior;  // row >= 2, col >= 2 and col < width
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  // Saturate a written dimension into DIM_MIN..hi.
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [CNT_W-1:0] hi);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (ve < EXT_W'(DIM_MIN)) begin
      return CNT_W'(DIM_MIN);
    end
    if (ve > EXT_W'(hi)) begin
      return hi;
    end
    return CNT_W'(ve);
  endfunction

endpackage

// ----- design/iwf_if.sv -----
// Channel interfaces of the interior wall finder: map cells in, removed
// cell positions out, and the configuration write channel.
// Depends on iwf_pkg.
interface iwf_in_if import iwf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] cell_code;
  logic              first_cell;

  modport source (output valid, output cell_code, output first_cell, input ready);
  modport sink   (input valid, input cell_code, input first_cell, output ready);
endinterface

interface iwf_out_if import iwf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] removed_row;
  logic [OUT_W-1:0] removed_col;

  modport source (output valid, output removed_row, output removed_col, input ready);
  modport sink   (input valid, input removed_row, input removed_col, output ready);
endinterface

interface iwf_cfg_if import iwf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/iwf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iwf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/iwf_scan.sv -----
// Raster position counters of the interior wall finder: column, row and
// end-of-map flag, plus the look-ahead read address of the line buffers.
// Depends on iwf_pkg.
module iwf_scan import iwf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             first,
  input  logic [CNT_W-1:0] width,
  input  logic [CNT_W-1:0] height,
  output pos_t             pos,
  output logic [COL_W-1:0] rd_addr
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;

  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             done_cur;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] row_inc;
  logic             wrap;

  // A first cell restarts the map before the cell itself is placed.
  always_comb begin
    col_cur  = first ? '0 : col_r;
    row_cur  = first ? '0 : row_r;
    done_cur = first ? 1'b0 : done_r;
    col_inc  = CNT_W'(col_cur) + CNT_W'(1);
    row_inc  = CNT_W'(row_cur) + CNT_W'(1);
    wrap     = (col_inc >= width);

    pos.active   = !done_cur && (CNT_W'(row_cur) < height);
    pos.interior = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) &&
                   (CNT_W'(col_cur) < width);
    pos.row      = row_cur;
    pos.col      = col_cur;
  end

  // Next position: advance along the row, wrap to the next row, and mark
  // the map finished after its last row or on a cell beyond it.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (step) begin
      if (!pos.active) begin
        col_nxt  = col_cur;
        row_nxt  = row_cur;
        done_nxt = 1'b1;
      end else if (wrap) begin
        col_nxt  = '0;
        row_nxt  = row_inc[ROW_W-1:0];
        done_nxt = (row_inc >= height);
      end else begin
        col_nxt  = col_inc[COL_W-1:0];
        row_nxt  = row_cur;
        done_nxt = 1'b0;
      end
    end
  end

  // The line buffers are read one item ahead so that the data for the
  // next cell is ready when it arrives.
  assign rd_addr = col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

  a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && first |=> !done_r)
    else $error("first cell did not restart the map");

  a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos.active && wrap |=> col_r == '0)
    else $error("column did not return to zero at the end of a row");

  a_past_map_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && !pos.active |=> done_r)
    else $error("cell beyond the map did not end the map");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(col_r) && $stable(row_r) && $stable(done_r))
    else $error("position moved without an item");

endmodule

// ----- design/iwf_window.sv -----
// 3x3 wall window of the interior wall finder: forms the new column from
// the line buffer data and the incoming cell, shifts the window, and
// decides whether the centre cell is an interior wall.
// Depends on iwf_pkg.
module iwf_window import iwf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              first,
  input  logic [CODE_W-1:0] cell_code,
  input  pos_t              pos,
  input  logic [LB_W-1:0]   lb_rdata,
  output logic [LB_W-1:0]   lb_wdata,
  output logic              lb_we,
  output logic              hit
);

  logic [5:0] window_r, window_nxt;
  logic [5:0] window_cur;
  logic       wall;
  logic [2:0] col3;

  // Column of three wall bits: two rows above, one row above, this cell.
  always_comb begin
    wall       = (cell_code == WALL_CODE);
    col3       = {lb_rdata[1], lb_rdata[0], wall};
    window_cur = first ? '0 : window_r;
  end

  // Line buffer update: the row above moves up, the new cell goes in.
  assign lb_wdata = {lb_rdata[0], wall};
  assign lb_we    = step && pos.active;

  // Centre cell is removed when the whole 3x3 block is wall at an active interior position.
  assign hit = pos.active && pos.interior && (window_cur == 6'h3F) && (col3 == 3'b111);

  always_comb begin
    window_nxt = window_r;
    if (step) begin
      window_nxt = pos.active ? {window_cur[2:0], col3} : window_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else begin
      window_r <= window_nxt;
    end
  end

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && first |=> window_r[5:3] == 3'b000)
    else $error("window not cleared by a first cell");

  a_hit_needs_wall: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> wall && lb_rdata == 2'b11 && window_r == 6'h3F)
    else $error("hit without a full wall block");

  // The rows above are not yet written on the first rows of a map, so the
  // column is compared bit for bit, unknown bits included.
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos.active |=> window_r[2:0] === $past(col3))
    else $error("window did not take the new column");

endmodule

// ----- design/interior_wall_finder_top.sv -----
// Interior wall finder top: streaming 3x3 erosion of wall cells in a map,
// built from iwf_scan, iwf_window and iwf_ram; needs iwf_pkg and iwf_if.
// A removal passes the input register, then the result register, before it is
// offered; the move between them waits while a result is held and not taken.
// Throughput: one item per cycle while no held result waits to be taken.
// Reset: counters, window and valid flags clear, size 64 by 64; line RAM kept.
module interior_wall_finder_top import iwf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  iwf_in_if.sink    in_ch,
  iwf_out_if.source out_ch,
  iwf_cfg_if.sink   cfg_ch
);

  // Configuration registers, held already clamped to the legal range.
  logic [CNT_W-1:0] width_r, width_nxt;
  logic [CNT_W-1:0] height_r, height_nxt;

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_first_r;
  logic              s1_adv;
  logic              in_fire;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_row_r;
  logic [OUT_W-1:0] out_col_r;

  pos_t             pos;
  logic [COL_W-1:0] rd_addr;
  logic [LB_W-1:0]  lb_rdata;
  logic [LB_W-1:0]  lb_wdata;
  logic             lb_we;
  logic             hit;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MAP_WIDTH:  width_nxt  = clamp_dim(cfg_ch.data, CNT_W'(MAX_WIDTH));
        REG_MAP_HEIGHT: height_nxt = clamp_dim(cfg_ch.data, CNT_W'(MAX_HEIGHT));
        default: begin
          width_nxt  = width_r;
          height_nxt = height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CNT_W'(DIM_RESET);
      height_r <= CNT_W'(DIM_RESET);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Handshake: the held item moves on when the result register is free.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code_r  <= in_ch.cell_code;
      s1_first_r <= in_ch.first_cell;
    end
  end

  // Position counters.
  iwf_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .first   (s1_first_r),
    .width   (width_r),
    .height  (height_r),
    .pos     (pos),
    .rd_addr (rd_addr)
  );

  // Both line buffers share one memory: bit 1 two rows up, bit 0 one row up.
  iwf_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (pos.col),
    .wdata (lb_wdata),
    .raddr (rd_addr),
    .rdata (lb_rdata)
  );

  // Window and decision.
  iwf_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .first     (s1_first_r),
    .cell_code (s1_code_r),
    .pos       (pos),
    .lb_rdata  (lb_rdata),
    .lb_wdata  (lb_wdata),
    .lb_we     (lb_we),
    .hit       (hit)
  );

  // Result register: the decided cell is one row up and one column left.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && hit) begin
      out_row_r <= OUT_W'(pos.row - ROW_W'(1));
      out_col_r <= OUT_W'(pos.col - COL_W'(1));
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.removed_row = out_row_r;
  assign out_ch.removed_col = out_col_r;

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item lost from the input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_code_r) && $stable(s1_first_r))
    else $error("stalled item changed");

  a_not_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_row_r != '0 && out_col_r != '0)
    else $error("border cell reported");

endmodule

// ----- tb/sv/iwf_removal_checker.sv -----
// Checker for the interior wall finder: watches the three channels, keeps its
// own copy of the map geometry and line buffers, and compares every removal.
// Depends on iwf_pkg and the channel interfaces in iwf_if.
`timescale 1ns / 1ps

module iwf_removal_checker import iwf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  iwf_in_if    in_mon,
  iwf_out_if   out_mon,
  iwf_cfg_if   cfg_mon,
  output int   fail_count,
  output int   outstanding
);

  // Reports stop after this many failures so that a broken block keeps the log short.
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
  } removal_t;

  removal_t         removals_due[$];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             wall_row_above [MAX_WIDTH];
  logic             wall_two_above [MAX_WIDTH];
  logic [5:0]       wall_window;
  int unsigned      scan_col;
  int unsigned      scan_row;
  logic             map_finished;
  int               errors = 0;

  // Saturate a written dimension into the range the line buffers support.
  function automatic int unsigned usable_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    int unsigned d;
    d = int'(v);
    if (d < DIM_MIN) return DIM_MIN;
    if (d > hi) return hi;
    return d;
  endfunction

  // Advance the erosion window by one map cell and say whether it uncovers
  // an interior wall cell, one row up and one column left of the new cell.
  task automatic erode_cell(input logic [CODE_W-1:0] code, input logic first,
                            output logic found, output removal_t spot);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic        wall;
    logic [2:0]  column_bits;
    found = 1'b0;
    spot  = '0;
    w     = usable_dim(width_reg, MAX_WIDTH);
    h     = usable_dim(height_reg, MAX_HEIGHT);
    wall  = (code == WALL_CODE);
    if (first) begin
      scan_col     = 0;
      scan_row     = 0;
      map_finished = 1'b0;
      wall_window  = '0;
    end
    if (map_finished || scan_row >= h) begin
      // Cells past the end of the map are dropped until the next first cell.
      map_finished = 1'b1;
    end else begin
      c = scan_col;
      r = scan_row;
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      column_bits       = {wall_two_above[c], wall_row_above[c], wall};
      wall_two_above[c] = wall_row_above[c];
      wall_row_above[c] = wall;
      if (r >= 2 && c >= 2 && c < w && wall_window == 6'h3F && column_bits == 3'b111) begin
        found    = 1'b1;
        spot.row = OUT_W'(r - 1);
        spot.col = OUT_W'(c - 1);
      end
      wall_window = {wall_window[2:0], column_bits};
      // A shrunken width wraps the row after the current cell.
      if (c + 1 >= w) begin
        scan_col = 0;
        scan_row = r + 1;
        if (scan_row >= h) map_finished = 1'b1;
      end else begin
        scan_col = c + 1;
      end
    end
  endtask

  // All three channels are sampled at the same edge; results are checked
  // before the new item is predicted, as a removal never follows its item
  // in the same cycle.
  always @(posedge clk) begin
    removal_t got;
    removal_t want;
    removal_t predicted;
    logic     hit;
    if (!rst_n) begin
      width_reg    = DIM_W'(DIM_RESET);
      height_reg   = DIM_W'(DIM_RESET);
      wall_window  = '0;
      scan_col     = 0;
      scan_row     = 0;
      map_finished = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        wall_row_above[i] = 1'b0;
        wall_two_above[i] = 1'b0;
      end
      removals_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.row = out_mon.removed_row;
        got.col = out_mon.removed_col;
        if (removals_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $error("removal at row %0d col %0d with none expected", got.row, got.col);
        end else begin
          want = removals_due.pop_front();
          if (got.row !== want.row) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $error("removed_row: expected %0d, actual %0d", want.row, got.row);
          end
          if (got.col !== want.col) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $error("removed_col: expected %0d, actual %0d", want.col, got.col);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_MAP_WIDTH:  width_reg  = cfg_mon.data;
          REG_MAP_HEIGHT: height_reg = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        erode_cell(in_mon.cell_code, in_mon.first_cell, hit, predicted);
        if (hit) removals_due.insert(removals_due.size(), predicted);
      end
    end
    fail_count  <= errors;
    outstanding <= removals_due.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the interior wall finder testbench: clock, reset, map stimulus,
// configuration writes, output back-pressure and the final verdict.
// Depends on iwf_pkg, iwf_if, interior_wall_finder_top and iwf_removal_checker.
`timescale 1ns / 1ps

module tb import iwf_pkg::*;;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  localparam int MIXED_ITEMS   = 200;
  localparam int QUIET_ITEMS   = 100;
  localparam int PRESS_DIM     = 8;
  localparam int WIDE_EXTRA    = 8;
  localparam int TALL_ROWS     = 30;

  logic clk;
  logic rst_n;
  int   fails;
  int   due;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   in_gap_pct  = 0;
  int   out_stall_pct = 0;
  bit   hold_request = 1'b0;
  bit   need_restart = 1'b1;
  int   width_now  = DIM_RESET;
  int   height_now = DIM_RESET;

  iwf_in_if  in_ch ();
  iwf_out_if out_ch ();
  iwf_cfg_if cfg_ch ();

  interior_wall_finder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  iwf_removal_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fails),
    .outstanding (due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int saturated(input int v, input int hi);
    int d;
    d = v & ((1 << DIM_W) - 1);
    if (d < DIM_MIN) return DIM_MIN;
    if (d > hi) return hi;
    return d;
  endfunction

  // Pick a map dimension: mostly small, sometimes below the minimum, and
  // for heights sometimes above the maximum.
  function automatic int pick_dim(input int hi_small, input bit allow_big);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, DIM_MIN - 1);
    if (sel == 1 && allow_big) return $urandom_range(MAX_HEIGHT + 1, (1 << DIM_W) - 1);
    return $urandom_range(DIM_MIN, hi_small);
  endfunction

  // Offer one map cell, possibly after an idle burst, and wait for acceptance.
  task automatic send_cell(input logic [CODE_W-1:0] code, input logic first);
    if (need_restart) begin
      first        = 1'b1;
      need_restart = 1'b0;
    end
    if ($urandom_range(1, 100) <= in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cell_code  <= code;
    in_ch.first_cell <= first;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // A run of cells: walls at the given rate, other cells random bytes,
  // and stray first-cell flags at the given rate per thousand.
  task automatic send_cells(input int n, input int wall_pct, input int restart_pml,
                            input bit fresh);
    logic [CODE_W-1:0] code;
    logic              first;
    for (int i = 0; i < n; i++) begin
      code  = ($urandom_range(1, 100) <= wall_pct) ? WALL_CODE : CODE_W'($urandom_range(0, 255));
      first = (fresh && i == 0) || ($urandom_range(1, 1000) <= restart_pml);
      send_cell(code, first);
    end
  endtask

  // Stop offering cells and wait until every predicted removal has come out,
  // then let the pipeline empty of cells that cause none.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write on an idle block. A wider map forces a fresh start so
  // that no line buffer entry is read before it is written.
  task automatic write_reg(input cfg_reg_t idx, input int data);
    int eff;
    drain_results();
    if (idx == REG_MAP_WIDTH) begin
      eff = saturated(data, MAX_WIDTH);
      if (eff > width_now) need_restart = 1'b1;
      width_now = eff;
    end else begin
      height_now = saturated(data, MAX_HEIGHT);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= DIM_W'(data);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One geometry setting followed by a few maps, some overrun, some broken
  // by stray first cells, some shrunk part way through.
  task automatic run_map_group();
    int rows;
    int wall_pct;
    write_reg(REG_MAP_WIDTH, pick_dim(12, 1'b0));
    write_reg(REG_MAP_HEIGHT, pick_dim(10, 1'b1));
    repeat ($urandom_range(1, 3)) begin
      rows = (height_now > 12) ? 12 : height_now;
      case ($urandom_range(0, 3))
        0:       wall_pct = 60;
        1:       wall_pct = 100;
        default: wall_pct = 90;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          // Shrink the width, then the height, while the map is open.
          send_cells(width_now * 3 + $urandom_range(0, width_now - 1), wall_pct, 0, 1'b1);
          write_reg(REG_MAP_WIDTH, $urandom_range(DIM_MIN, width_now));
          send_cells(width_now * 2 + 1, wall_pct, 0, 1'b0);
          write_reg(REG_MAP_HEIGHT, $urandom_range(DIM_MIN, 5));
          send_cells(width_now * 2, wall_pct, 0, 1'b0);
        end
        1: send_cells(width_now * rows + $urandom_range(1, 2 * width_now), wall_pct, 0, 1'b1);
        2: send_cells(width_now * rows, wall_pct, 30, 1'b1);
        3: send_cells($urandom_range(1, width_now * rows), wall_pct, 0, 1'b1);
        default: send_cells(width_now * rows, wall_pct, 0, 1'b1);
      endcase
    end
  endtask

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(1, 100) <= out_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cell_code  = '0;
    in_ch.first_cell = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_MAP_WIDTH;
    cfg_ch.data      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3 by 3 maps from values below the minimum, a full block of
    // walls, cells past the end, near-wall codes and a restart mid-map.
    write_reg(REG_MAP_WIDTH, 0);
    write_reg(REG_MAP_HEIGHT, 2);
    send_cells(9, 100, 0, 1'b1);
    send_cell(CODE_W'(0), 1'b0);
    send_cell(CODE_W'(255), 1'b0);
    send_cell(WALL_CODE, 1'b1);
    send_cell(WALL_CODE - 1, 1'b0);
    send_cell(WALL_CODE + 1, 1'b0);
    send_cell(WALL_CODE, 1'b0);
    send_cells(9, 100, 0, 1'b1);

    // Small maps with idling switched on and off per group.
    while (items_sent < MIXED_ITEMS) begin
      in_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : 20;
      out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      run_map_group();
    end

    // Fully walled map with the result side held off long enough for the
    // block to fill up and stall its input.
    in_gap_pct    = 10;
    out_stall_pct = 10;
    write_reg(REG_MAP_WIDTH, PRESS_DIM);
    write_reg(REG_MAP_HEIGHT, PRESS_DIM);
    hold_request = 1'b1;
    send_cells(PRESS_DIM * PRESS_DIM, 100, 0, 1'b1);

    // Widest map from an oversized width: one full row and the start of the next.
    write_reg(REG_MAP_WIDTH, (1 << DIM_W) - 1);
    write_reg(REG_MAP_HEIGHT, DIM_MIN);
    send_cells(MAX_WIDTH + WIDE_EXTRA, 97, 0, 1'b1);

    // Tallest map from an oversized height, a few dozen rows of it.
    write_reg(REG_MAP_WIDTH, DIM_MIN);
    write_reg(REG_MAP_HEIGHT, (1 << DIM_W) - 1);
    send_cells(DIM_MIN * TALL_ROWS, 97, 0, 1'b1);

    // Closing stretch at full rate on both sides.
    in_gap_pct    = 0;
    out_stall_pct = 0;
    items_sent    = 0;
    while (items_sent < QUIET_ITEMS) run_map_group();

    drain_results();
    if (fails == 0 && due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
